>>> rtl/dns_response_a_record_parser_core_defines.svh
// assertion helpers shared by the core and output-buffer rtl files
`ifndef DNS_RESPONSE_A_RECORD_PARSER_CORE_DEFINES_SVH
`define DNS_RESPONSE_A_RECORD_PARSER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define DNSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dnsp assertion failed");
// next-cycle implication, checked outside reset
`define DNSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dnsp assertion failed");
`else
`define DNSP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DNSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/dnsp_pkg.sv
package dnsp_pkg;

  localparam int MAX_MESSAGE_BYTES = 16384;
  localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

  localparam logic [15:0] FLAGS_STD_RESPONSE = 16'h8180;
  localparam logic [15:0] TYPE_A = 16'h0001;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [31:0] address;
    logic        id_match;
    logic        header_ok;
    logic        has_answers;
  } out_word_t;

endpackage

>>> rtl/dns_response_a_record_parser_core.sv
// channel  | signals                           | word
// ---------+-----------------------------------+-----------------------------------
// in       | in_valid, in_ready, in_data       | msg_byte, last_byte
// out      | out_valid, out_ready, out_data    | found, address, id/header/answer flags
// cfg      | cfg_valid, cfg_ready, cfg_data    | expected_id (16 bits)
//
// one input word per cycle while in_ready is high; the result word for a message is
// registered into the output buffer when the word carrying last_byte is taken
// rst_n is synchronous, active low; it clears the parse state and expected_id
// the output side is a two-entry buffer, so in_ready drops only when both
// entries hold results that have not been taken
// cfg_ready is always high; write expected_id only while no message is in flight

`include "dns_response_a_record_parser_core_defines.svh"

module dns_response_a_record_parser_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dnsp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dnsp_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  logic [15:0]         exp_id_r;
  logic                in_fire;
  logic                res_valid;
  dnsp_pkg::out_word_t res_word;
  logic                space_ok;

  // configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r <= 16'd0;
    end else if (cfg_valid) begin
      exp_id_r <= cfg_data;
    end
  end

  assign in_ready = space_ok;
  assign in_fire  = in_valid && in_ready;

  // per-byte parser: state registers plus one step of next-state logic
  dnsp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_fire   (in_fire),
    .byte_word   (in_data),
    .expected_id (exp_id_r),
    .res_valid   (res_valid),
    .res_word    (res_word)
  );

  // result register with a skid entry behind it
  dnsp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_word  (res_word),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a written identifier is what the parser compares against
  `DNSP_ASSERT_NEXT(a_cfg_taken, clk, rst_n, cfg_valid, exp_id_r == $past(cfg_data))
  // a result only follows a taken final byte
  `DNSP_ASSERT_NOW(a_result_from_last, clk, rst_n, res_valid, in_fire && in_data.last_byte)
  // input stalls only while a result is waiting on out
  `DNSP_ASSERT_NOW(a_stall_means_full, clk, rst_n, !in_ready, out_valid)

endmodule

>>> rtl/dnsp_parse.sv
module dnsp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_fire,
  input  dnsp_pkg::in_word_t byte_word,
  input  logic [15:0]        expected_id,
  output logic               res_valid,
  output dnsp_pkg::out_word_t res_word
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_QLEN,
    PH_QLABEL,
    PH_QTAIL,
    PH_ANSHDR,
    PH_ASKIP,
    PH_ADDR,
    PH_DONE
  } phase_t;

  localparam int POS_W = dnsp_pkg::POS_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(dnsp_pkg::MAX_MESSAGE_BYTES);

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      skip_r, skip_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic             fl_id_r, fl_id_nxt;
  logic             fl_hdr_r, fl_hdr_nxt;
  logic             fl_ans_r, fl_ans_nxt;
  logic             fl_type_r, fl_type_nxt;
  logic [15:0]      word;
  logic [7:0]       b;

  assign b    = byte_word.msg_byte;
  assign word = {hold_r, b};

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    skip_nxt    = skip_r;
    hold_nxt    = hold_r;
    addr_nxt    = addr_r;
    fl_id_nxt   = fl_id_r;
    fl_hdr_nxt  = fl_hdr_r;
    fl_ans_nxt  = fl_ans_r;
    fl_type_nxt = fl_type_r;
    if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
      case (phase_r)
        PH_HEADER: begin
          if (pos_r inside {POS_W'(0), POS_W'(2), POS_W'(6)}) begin
            hold_nxt = b;
          end
          if (pos_r == POS_W'(1)) fl_id_nxt = (word == expected_id);
          if (pos_r == POS_W'(3)) fl_hdr_nxt = (word == dnsp_pkg::FLAGS_STD_RESPONSE);
          if (pos_r == POS_W'(7)) fl_ans_nxt = (word != 16'd0);
          if (pos_r == POS_W'(11)) phase_nxt = PH_QLEN;
        end
        PH_QLEN: begin
          if (b == 8'd0) begin
            phase_nxt = PH_QTAIL;
            skip_nxt  = 16'd4;
          end else begin
            phase_nxt = PH_QLABEL;
            skip_nxt  = {8'd0, b};
          end
        end
        PH_QLABEL, PH_QTAIL, PH_ASKIP: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_nxt == 16'd0) begin
            phase_nxt = (phase_r == PH_QLABEL) ? PH_QLEN : PH_ANSHDR;
          end
        end
        PH_ANSHDR: begin
          // offset within the answer header: name, type, class, ttl, rdlength
          if (skip_r inside {16'd2, 16'd10}) hold_nxt = b;
          if (skip_r == 16'd3) fl_type_nxt = (word == dnsp_pkg::TYPE_A);
          if (skip_r >= 16'd11) begin
            if (fl_type_r) begin
              phase_nxt = PH_ADDR;
              skip_nxt  = 16'd0;
              addr_nxt  = 32'd0;
            end else if (word == 16'd0) begin
              skip_nxt = 16'd0;
            end else begin
              phase_nxt = PH_ASKIP;
              skip_nxt  = word;
            end
          end else begin
            skip_nxt = skip_r + 16'd1;
          end
        end
        PH_ADDR: begin
          addr_nxt = {addr_r[23:0], b};
          skip_nxt = skip_r + 16'd1;
          if (skip_nxt >= 16'd4) phase_nxt = PH_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  // result is formed from the post-byte state on the final byte
  always_comb begin
    res_valid            = byte_fire && byte_word.last_byte;
    res_word.found       = (phase_nxt == PH_DONE);
    res_word.address     = (phase_nxt == PH_DONE) ? addr_nxt : 32'd0;
    res_word.id_match    = fl_id_nxt;
    res_word.header_ok   = fl_hdr_nxt;
    res_word.has_answers = fl_ans_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_fire && byte_word.last_byte)) begin
      phase_r   <= PH_HEADER;
      pos_r     <= '0;
      skip_r    <= '0;
      hold_r    <= '0;
      addr_r    <= '0;
      fl_id_r   <= 1'b0;
      fl_hdr_r  <= 1'b0;
      fl_ans_r  <= 1'b0;
      fl_type_r <= 1'b0;
    end else if (byte_fire) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      skip_r    <= skip_nxt;
      hold_r    <= hold_nxt;
      addr_r    <= addr_nxt;
      fl_id_r   <= fl_id_nxt;
      fl_hdr_r  <= fl_hdr_nxt;
      fl_ans_r  <= fl_ans_nxt;
      fl_type_r <= fl_type_nxt;
    end
  end

endmodule

>>> rtl/dnsp_out_buf.sv
`include "dns_response_a_record_parser_core_defines.svh"

module dnsp_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  dnsp_pkg::out_word_t res_word,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output dnsp_pkg::out_word_t out_data
);

  dnsp_pkg::out_word_t main_r, skid_r;
  logic                main_valid_r, skid_valid_r;
  logic                pop;

  assign pop       = main_valid_r && out_ready;
  assign space_ok  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
        if (res_valid) begin
          skid_r       <= res_word;
          skid_valid_r <= 1'b1;
        end
      end else begin
        main_valid_r <= res_valid;
        main_r       <= res_word;
      end
    end else if (res_valid) begin
      if (!main_valid_r) begin
        main_r       <= res_word;
        main_valid_r <= 1'b1;
      end else begin
        skid_r       <= res_word;
        skid_valid_r <= 1'b1;
      end
    end
  end

  `DNSP_ASSERT_NOW(a_skid_behind_main, clk, rst_n, skid_valid_r, main_valid_r)
  `DNSP_ASSERT_NOW(a_no_push_when_full, clk, rst_n, res_valid, !skid_valid_r || pop)
  `DNSP_ASSERT_NOW(a_addr_zero_unfound, clk, rst_n, main_valid_r && !main_r.found,
                   main_r.address == 32'd0)
  `DNSP_ASSERT_NEXT(a_result_lands, clk, rst_n, res_valid, main_valid_r)

endmodule
